@@ design/tlpt_pkg.sv @@
// Package with the types, codes and sizes of the two-level page table engine.
`default_nettype none
package tlpt_pkg;

  localparam int NUM_TABLES  = 16;
  localparam int DIR_ENTRIES = 1024;
  localparam int TBL_ENTRIES = 1024;
  localparam int PAGE_SHIFT  = 12;

  localparam int DIR_W   = $clog2(DIR_ENTRIES);
  localparam int IDX_W   = $clog2(TBL_ENTRIES);
  localparam int TBL_W   = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int NFT_W   = $clog2(NUM_TABLES + 1);
  localparam int ENT_AW  = TBL_W + IDX_W;
  localparam int FLAG_W  = PAGE_SHIFT;
  localparam int FRAME_W = 32 - PAGE_SHIFT;

  typedef enum logic [1:0] {
    FUNC_MAP    = 2'd0,
    FUNC_UNMAP  = 2'd1,
    FUNC_LOOKUP = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_NO_TABLE  = 2'd1,
    STATUS_EXHAUSTED = 2'd2
  } status_t;

  typedef struct packed {
    func_t              func;
    logic [31:0]        virtual_addr;
    logic [31:0]        phys_addr;
    logic [FLAG_W-1:0]  entry_flags;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] frame_addr;
    status_t     status;
  } out_item_t;

  typedef struct packed {
    logic              valid;
    logic [FLAG_W-1:0] flags;
    logic [TBL_W-1:0]  tbl;
  } dir_slot_t;

  localparam int DIR_SLOT_W = $bits(dir_slot_t);

endpackage
`default_nettype wire

@@ design/tlpt_ram.sv @@
// Generic simple dual-port synchronous RAM with a registered read port.
`default_nettype none
module tlpt_ram #(
  parameter int WIDTH = 32,
  parameter int AW    = 10
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ design/two_level_page_table_engine.sv @@
// Top level of the two-level page table engine: sequencer around two RAMs.
`default_nettype none
// Sequence: a request reads its directory slot and is decided in DIR; a lookup with a
// table reads its entry in ENT; a new table is cleared in CLEAR, then written in FILL.
// Throughput: one item at a time; busy drops in the cycle that done is shown, so
// a new transfer can follow at once. The sequencer's busy state sets this.
// Reset: after rst every directory RAM slot is written invalid, with busy high.
// The result receiver cannot stall; each result is shown for exactly one cycle.
module two_level_page_table_engine (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output      logic                 busy,
  input  wire tlpt_pkg::in_item_t   req,
  output      logic                 done,
  output      tlpt_pkg::out_item_t  rsp
);

  import tlpt_pkg::*;

  // One-hot sequencer states. INIT clears the directory after reset, DIR
  // evaluates the directory slot, CLEAR zeroes a freshly allocated table,
  // FILL writes the entry after that clear, and ENT returns lookup data.
  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_DIR   = 6'b000100,
    S_CLEAR = 6'b001000,
    S_FILL  = 6'b010000,
    S_ENT   = 6'b100000
  } state_t;

  state_t             state, state_next;
  in_item_t           req_q, req_q_next;
  logic [IDX_W-1:0]   clear_count, clear_count_next;
  logic [NFT_W-1:0]   next_free_table, next_free_table_next;
  logic [TBL_W-1:0]   alloc_table, alloc_table_next;
  logic               done_next;
  out_item_t          rsp_next;

  // Memory port controls.
  logic               dir_we, dir_re;
  logic [DIR_W-1:0]   dir_waddr, dir_raddr;
  dir_slot_t          dir_wdata, dir_rdata;
  logic               ent_we, ent_re;
  logic [ENT_AW-1:0]  ent_waddr, ent_raddr;
  logic [31:0]        ent_wdata, ent_rdata;

  logic [DIR_W-1:0]   req_dir_idx;
  logic [IDX_W-1:0]   req_tbl_idx;
  logic [31:0]        new_entry;

  tlpt_ram #(.WIDTH(DIR_SLOT_W), .AW(DIR_W)) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .re    (dir_re),
    .raddr (dir_raddr),
    .rdata (dir_rdata)
  );

  tlpt_ram #(.WIDTH(32), .AW(ENT_AW)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  assign busy        = (state != S_IDLE);
  assign req_dir_idx = req_q.virtual_addr[31:32-DIR_W];
  assign req_tbl_idx = req_q.virtual_addr[PAGE_SHIFT+IDX_W-1:PAGE_SHIFT];
  // A mapped entry holds the frame bits of the physical address and the flags.
  assign new_entry   = {req_q.phys_addr[31:PAGE_SHIFT], req_q.entry_flags};

  always_comb begin
    state_next           = state;
    req_q_next           = req_q;
    clear_count_next     = clear_count;
    next_free_table_next = next_free_table;
    alloc_table_next     = alloc_table;
    done_next            = 1'b0;
    rsp_next             = '{hit: 1'b0, frame_addr: 32'd0, status: STATUS_DONE};

    dir_we    = 1'b0;
    dir_waddr = req_dir_idx;
    dir_wdata = '0;
    dir_re    = 1'b0;
    dir_raddr = req.virtual_addr[31:32-DIR_W];
    ent_we    = 1'b0;
    ent_waddr = {dir_rdata.tbl, req_tbl_idx};
    ent_wdata = 32'd0;
    ent_re    = 1'b0;
    ent_raddr = {dir_rdata.tbl, req_tbl_idx};

    case (state)
      S_INIT: begin
        // Every directory slot is written invalid, one slot per cycle.
        dir_we           = 1'b1;
        dir_waddr        = clear_count;
        clear_count_next = clear_count + 1'b1;
        if (clear_count == {IDX_W{1'b1}}) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_q_next = req;
          dir_re     = 1'b1;
          state_next = S_DIR;
        end
      end
      S_DIR: begin
        case (req_q.func)
          FUNC_MAP: begin
            if (dir_rdata.valid) begin
              ent_we     = 1'b1;
              ent_wdata  = new_entry;
              done_next  = 1'b1;
              state_next = S_IDLE;
            end else if (next_free_table == NFT_W'(NUM_TABLES)) begin
              rsp_next.status = STATUS_EXHAUSTED;
              done_next       = 1'b1;
              state_next      = S_IDLE;
            end else begin
              // Take the next pool table and record it in the slot.
              dir_we               = 1'b1;
              dir_wdata.valid      = 1'b1;
              dir_wdata.flags      = req_q.entry_flags;
              dir_wdata.tbl        = next_free_table[TBL_W-1:0];
              alloc_table_next     = next_free_table[TBL_W-1:0];
              next_free_table_next = next_free_table + 1'b1;
              state_next           = S_CLEAR;
            end
          end
          FUNC_UNMAP: begin
            if (dir_rdata.valid) begin
              ent_we = 1'b1;
            end else begin
              rsp_next.status = STATUS_NO_TABLE;
            end
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
          FUNC_LOOKUP: begin
            if (dir_rdata.valid) begin
              ent_re     = 1'b1;
              state_next = S_ENT;
            end else begin
              rsp_next.status = STATUS_NO_TABLE;
              done_next       = 1'b1;
              state_next      = S_IDLE;
            end
          end
          default: begin
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_CLEAR: begin
        ent_we           = 1'b1;
        ent_waddr        = {alloc_table, clear_count};
        clear_count_next = clear_count + 1'b1;
        if (clear_count == {IDX_W{1'b1}}) begin
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        ent_we     = 1'b1;
        ent_waddr  = {alloc_table, req_tbl_idx};
        ent_wdata  = new_entry;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      S_ENT: begin
        // Any nonzero entry is a hit, even one that holds only flag bits.
        if (ent_rdata != 32'd0) begin
          rsp_next.hit        = 1'b1;
          rsp_next.frame_addr = {ent_rdata[31:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
        end
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_INIT;
      clear_count     <= '0;
      next_free_table <= '0;
      done            <= 1'b0;
    end else begin
      state           <= state_next;
      clear_count     <= clear_count_next;
      next_free_table <= next_free_table_next;
      done            <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    req_q       <= req_q_next;
    alloc_table <= alloc_table_next;
    rsp         <= rsp_next;
  end

`ifndef SYNTHESIS
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_DIR || $past(state) == S_FILL || $past(state) == S_ENT))
    else $error("done raised without a finished operation");

  a_accept_to_dir: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_DIR))
    else $error("accepted transfer did not start a directory read");

  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    next_free_table <= NFT_W'(NUM_TABLES))
    else $error("table pool counter beyond pool size");

  a_exhausted_no_alloc: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == STATUS_EXHAUSTED) |-> $stable(next_free_table))
    else $error("table allocated on an exhausted pool");

  a_hit_is_done: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.hit) |-> (rsp.status == STATUS_DONE))
    else $error("lookup hit reported with an error status");
`endif

endmodule
`default_nettype wire

@@ test/two_level_page_table_engine_tb.sv @@
// Self-checking testbench for the two-level page table engine: directed and random walks.
module two_level_page_table_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tlpt_pkg::*;

  // Function code 3 has no operation behind it. The block must answer it like an idle
  // request and leave the tables alone.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Cycles to linger once every expected answer is in, to catch a stray strobe.
  localparam int SETTLE_CYCLES = 16;
  localparam int RESET_CYCLES  = 10;
  localparam int RANDOM_OPS    = 1030;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  in_item_t  req;
  logic      done;
  out_item_t rsp;

  two_level_page_table_engine DUT (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Shadow copy of the page table. The directory and the entries track what the
  // block must hold after each accepted transfer. Tables are cleared on allocation,
  // so an entry is never read before it has been written.
  dir_slot_t   dir_shadow [DIR_ENTRIES];
  logic [31:0] pte_shadow [NUM_TABLES][TBL_ENTRIES];
  int unsigned tables_handed_out;

  // Answers still owed by the block, oldest first.
  out_item_t   pending_answers[$];

  int unsigned transfers_sent;
  int unsigned answers_checked;
  int unsigned hits_seen;
  int unsigned no_table_seen;
  int unsigned exhausted_seen;
  int unsigned mismatches;

  // When set, the sender offers items back to back with no idle cycles in between.
  bit back_to_back;

  function automatic in_item_t make_op(input logic [1:0] code, input logic [31:0] va,
                                       input logic [31:0] pa, input logic [FLAG_W-1:0] fl);
    in_item_t op;
    op.func         = func_t'(code);
    op.virtual_addr = va;
    op.phys_addr    = pa;
    op.entry_flags  = fl;
    return op;
  endfunction

  // Walks the shadow table for one request and applies its side effects. A map into an
  // empty directory slot first takes the next pool table and zeroes it; when the pool
  // is used up the map is refused and nothing changes.
  function automatic out_item_t walk_page_table(input in_item_t op);
    out_item_t          answer;
    logic [DIR_W-1:0]   di;
    logic [IDX_W-1:0]   ti;
    logic [31:0]        pte;
    logic [1:0]         code;
    answer        = '0;
    answer.status = STATUS_DONE;
    di   = op.virtual_addr[31:22];
    ti   = op.virtual_addr[21:12];
    code = op.func;
    case (code)
      FUNC_MAP: begin
        if (!dir_shadow[di].valid && tables_handed_out >= NUM_TABLES) begin
          answer.status = STATUS_EXHAUSTED;
        end else begin
          if (!dir_shadow[di].valid) begin
            dir_shadow[di].valid = 1'b1;
            dir_shadow[di].flags = op.entry_flags;
            dir_shadow[di].tbl   = TBL_W'(tables_handed_out);
            for (int i = 0; i < TBL_ENTRIES; i++) begin
              pte_shadow[tables_handed_out][i] = '0;
            end
            tables_handed_out++;
          end
          pte_shadow[dir_shadow[di].tbl][ti] = {op.phys_addr[31:PAGE_SHIFT], op.entry_flags};
        end
      end
      FUNC_UNMAP: begin
        if (!dir_shadow[di].valid) begin
          answer.status = STATUS_NO_TABLE;
        end else begin
          pte_shadow[dir_shadow[di].tbl][ti] = '0;
        end
      end
      FUNC_LOOKUP: begin
        if (!dir_shadow[di].valid) begin
          answer.status = STATUS_NO_TABLE;
        end else begin
          pte = pte_shadow[dir_shadow[di].tbl][ti];
          // Any nonzero entry counts, even one that holds nothing but flags.
          if (pte != '0) begin
            answer.hit        = 1'b1;
            answer.frame_addr = {pte[31:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
          end
        end
      end
      default: begin
      end
    endcase
    return answer;
  endfunction

  // Offers one request and waits for the block to take it. The sender idles a random
  // number of cycles first unless a back-to-back stretch is running. Start stays high
  // from one transfer into the next when there is no gap, so it is never lowered and
  // raised within one time step.
  task automatic send_op(input in_item_t op);
    int unsigned gap;
    gap = back_to_back ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= op;
    // Right after the edge busy still shows the value the block sampled, so this loop
    // leaves at the edge where the transfer took place.
    do @(posedge clk); while (busy);
    pending_answers.push_back(walk_page_table(op));
    transfers_sent++;
  endtask

  // Answer checker. Each strobe is compared with the oldest owed answer. Values are
  // read right after the edge, which is what the block presented during the cycle.
  always @(posedge clk) begin
    out_item_t owed;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        $error("answer with none owed: hit %0b frame_addr %08h status %0d",
               rsp.hit, rsp.frame_addr, rsp.status);
        mismatches++;
      end else begin
        owed = pending_answers.pop_front();
        answers_checked++;
        if (rsp.hit !== owed.hit) begin
          $error("hit: expected %0b, got %0b", owed.hit, rsp.hit);
          mismatches++;
        end
        if (rsp.frame_addr !== owed.frame_addr) begin
          $error("frame_addr: expected %08h, got %08h", owed.frame_addr, rsp.frame_addr);
          mismatches++;
        end
        if (rsp.status !== owed.status) begin
          $error("status: expected %0d, got %0d", owed.status, rsp.status);
          mismatches++;
        end
        if (owed.hit) begin
          hits_seen++;
        end
        if (owed.status == STATUS_NO_TABLE) begin
          no_table_seen++;
        end
        if (owed.status == STATUS_EXHAUSTED) begin
          exhausted_seen++;
        end
      end
    end
  end

  // Requests against a directory with no tables yet: unmap and lookup must report that
  // no second-level table is there, and the unused code must answer plainly.
  task automatic test_empty_directory();
    send_op(make_op(FUNC_UNMAP, 32'h0140_3000, 32'h0, 12'h0));
    send_op(make_op(FUNC_LOOKUP, 32'h0140_3abc, 32'hFFFF_FFFF, 12'hFFF));
    send_op(make_op(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF));
  endtask

  // First maps at both ends of the address space allocate tables, then lookups read
  // them back. A lookup of a never-mapped entry in a live table must miss cleanly.
  task automatic test_map_and_lookup();
    send_op(make_op(FUNC_MAP, 32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF));
    send_op(make_op(FUNC_LOOKUP, 32'h0000_0fff, 32'h0, 12'h0));
    send_op(make_op(FUNC_MAP, 32'hFFFF_FFFF, 32'h1234_5abc, 12'h000));
    send_op(make_op(FUNC_LOOKUP, 32'hFFFF_F000, 32'h0, 12'h0));
    send_op(make_op(FUNC_LOOKUP, 32'h0000_1000, 32'h0, 12'h0));
    send_op(make_op(FUNC_LOOKUP, 32'hFFC0_0000, 32'h0, 12'h0));
  endtask

  // An entry with a zero frame but nonzero flags still counts as a mapping, while an
  // entry written as all zeros does not.
  task automatic test_flags_only_entry();
    send_op(make_op(FUNC_MAP, 32'h0000_2000, 32'h0000_0fff, 12'h001));
    send_op(make_op(FUNC_LOOKUP, 32'h0000_2000, 32'h0, 12'h0));
    send_op(make_op(FUNC_MAP, 32'h0000_3000, 32'h0000_0fff, 12'h000));
    send_op(make_op(FUNC_LOOKUP, 32'h0000_3000, 32'h0, 12'h0));
  endtask

  // A remap overwrites the entry in place, an unmap clears it, and the unused code on
  // a live table changes nothing.
  task automatic test_remap_and_unmap();
    send_op(make_op(FUNC_MAP, 32'h0000_0000, 32'h8765_4000, 12'h5A5));
    send_op(make_op(FUNC_LOOKUP, 32'h0000_0000, 32'h0, 12'h0));
    send_op(make_op(FUNC_UNUSED, 32'h0000_0000, 32'h0, 12'h0));
    send_op(make_op(FUNC_LOOKUP, 32'h0000_0000, 32'h0, 12'h0));
    send_op(make_op(FUNC_UNMAP, 32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF));
    send_op(make_op(FUNC_LOOKUP, 32'h0000_0000, 32'h0, 12'h0));
    send_op(make_op(FUNC_UNMAP, 32'hFFFF_FFFF, 32'h0, 12'h0));
    send_op(make_op(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0, 12'h0));
  endtask

  // Random traffic. Most requests land on a handful of hot directory slots and table
  // indexes so that maps, lookups and unmaps meet the same entries; the rest roam the
  // whole address space, which allocates fresh tables until the pool runs dry.
  task automatic test_random_traffic();
    logic [DIR_W-1:0]  hot_dir [12];
    logic [IDX_W-1:0]  hot_idx [8];
    logic [DIR_W-1:0]  di;
    logic [IDX_W-1:0]  ti;
    logic [31:0]       pa;
    logic [FLAG_W-1:0] fl;
    logic [1:0]        code;
    int unsigned       pick;
    hot_dir[0] = '0;
    hot_dir[1] = '1;
    for (int i = 2; i < 12; i++) begin
      hot_dir[i] = DIR_W'($urandom);
    end
    hot_idx[0] = '0;
    hot_idx[1] = '1;
    hot_idx[2] = IDX_W'(1);
    hot_idx[3] = IDX_W'(2);
    for (int i = 4; i < 8; i++) begin
      hot_idx[i] = IDX_W'($urandom);
    end
    for (int n = 0; n < RANDOM_OPS; n++) begin
      // Every so often switch between idling and back-to-back stretches.
      if (n % 64 == 0) begin
        back_to_back = ($urandom_range(0, 3) == 0);
      end
      di = ($urandom_range(0, 4) == 0) ? DIR_W'($urandom) : hot_dir[$urandom_range(0, 11)];
      ti = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom) : hot_idx[$urandom_range(0, 7)];
      pa = ($urandom_range(0, 15) == 0) ? 32'($urandom_range(0, 4095)) : 32'($urandom);
      fl = ($urandom_range(0, 15) == 0) ? '0 : FLAG_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        code = FUNC_MAP;
      end else if (pick < 55) begin
        code = FUNC_UNMAP;
      end else if (pick < 95) begin
        code = FUNC_LOOKUP;
      end else begin
        code = FUNC_UNUSED;
      end
      send_op(make_op(code, {di, ti, 12'($urandom)}, pa, fl));
    end
    back_to_back = 1'b0;
  endtask

  // Takes whatever pool tables are left, then maps into one more empty slot: that map
  // must be refused, and the slot must still read as having no table.
  task automatic test_pool_exhaustion();
    logic [DIR_W-1:0] di;
    di = DIR_W'(512);
    while (tables_handed_out < NUM_TABLES) begin
      while (dir_shadow[di].valid) di++;
      send_op(make_op(FUNC_MAP, {di, 22'($urandom)}, $urandom, FLAG_W'($urandom)));
    end
    while (dir_shadow[di].valid) di++;
    send_op(make_op(FUNC_MAP, {di, 22'($urandom)}, $urandom, FLAG_W'($urandom)));
    send_op(make_op(FUNC_LOOKUP, {di, 22'($urandom)}, 32'h0, 12'h0));
    send_op(make_op(FUNC_UNMAP, {di, 22'($urandom)}, 32'h0, 12'h0));
  endtask

  initial begin
    rst               = 1'b1;
    start             = 1'b0;
    req               = '0;
    back_to_back      = 1'b0;
    tables_handed_out = 0;
    transfers_sent    = 0;
    answers_checked   = 0;
    hits_seen         = 0;
    no_table_seen     = 0;
    exhausted_seen    = 0;
    mismatches        = 0;
    for (int i = 0; i < DIR_ENTRIES; i++) begin
      dir_shadow[i] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // The block sweeps its directory after reset with busy high; send_op simply waits.
    test_empty_directory();
    test_map_and_lookup();
    test_flags_only_entry();
    test_remap_and_unmap();
    test_random_traffic();
    test_pool_exhaustion();

    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d transfers and checked %0d answers: %0d lookup hits,",
             transfers_sent, answers_checked, hits_seen);
    $display("%0d answers without a table, %0d refused maps after %0d tables were handed out.",
             no_table_seen, exhausted_seen, tables_handed_out);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog. A correct run needs well under half a millisecond even with every table
  // cleared and every gap at its longest, so 3 ms means the block has hung.
  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ filelist.f @@
design/tlpt_pkg.sv
design/tlpt_ram.sv
design/two_level_page_table_engine.sv
test/two_level_page_table_engine_tb.sv
